// ===== src/dsk_pkg.sv =====
// ----------------------------------------------------------------------------
// dsk_pkg
// Shared widths, constants and helpers for the lidar point deskew pipeline.
// ----------------------------------------------------------------------------
package dsk_pkg;

    localparam int CORDIC_STEPS = 25;

    localparam int VEC_XW    = 60;
    localparam int VEC_ZW    = 28;
    localparam int VEC_AUX_W = 125;

    localparam int DIV_RW    = 21;
    localparam int DIV_QW    = 18;
    localparam int SPAN_W    = 20;
    localparam int DIV_AUX_W = 97;

    localparam int DW        = 35;
    localparam int ROT_XW    = 34;
    localparam int ROT_ZW    = 28;
    localparam int ROT_AUX_W = 124;

    localparam logic [23:0] ATAN_TAB [CORDIC_STEPS] = '{
        24'd13176795, 24'd7778716, 24'd4110060, 24'd2086331, 24'd1047214,
        24'd524117, 24'd262123, 24'd131069, 24'd65536, 24'd32768,
        24'd16384, 24'd8192, 24'd4096, 24'd2048, 24'd1024, 24'd512,
        24'd256, 24'd128, 24'd64, 24'd32, 24'd16, 24'd8, 24'd4, 24'd2, 24'd1
    };

    localparam logic [65:0]        MIN_RANGE_SQ = 66'd429497;
    localparam logic signed [20:0] TWO_PI_Q16   = 21'sd411775;
    localparam logic signed [29:0] PI_Q24       = 30'sd52707179;
    localparam logic signed [29:0] HALF_PI_Q24  = 30'sd26353589;
    localparam logic signed [29:0] TWO_PI_Q24   = 30'sd105414357;
    localparam logic signed [ROT_XW-1:0] INV_GAIN_Q30 = ROT_XW'(652032874);
    localparam logic [DIV_QW-1:0]  FRAC_MAX     = 18'd131072;

    typedef enum logic [2:0] {
        REG_START = 3'd0,
        REG_SPAN  = 3'd1,
        REG_SHX   = 3'd2,
        REG_SHY   = 3'd3,
        REG_SHZ   = 3'd4,
        REG_YAW   = 3'd5
    } cfg_idx_t;

    function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
        logic signed [31:0] r;
        if (v > 68'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -68'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// ===== src/dsk_vec_cell.sv =====
// ----------------------------------------------------------------------------
// dsk_vec_cell
// One vectoring CORDIC micro-rotation, registered.
// ----------------------------------------------------------------------------
module dsk_vec_cell import dsk_pkg::*; #(
    parameter int STEP = 0
) (
    input  logic                     aclk,
    input  logic                     en,
    input  logic signed [VEC_XW-1:0] x_i,
    input  logic signed [VEC_XW-1:0] y_i,
    input  logic signed [VEC_ZW-1:0] z_i,
    input  logic [VEC_AUX_W-1:0]     aux_i,
    output logic signed [VEC_XW-1:0] x_o,
    output logic signed [VEC_XW-1:0] y_o,
    output logic signed [VEC_ZW-1:0] z_o,
    output logic [VEC_AUX_W-1:0]     aux_o
);

    localparam logic signed [VEC_ZW-1:0] ANG = VEC_ZW'(ATAN_TAB[STEP]);

    logic signed [VEC_XW-1:0] x_reg, y_reg, sx, sy;
    logic signed [VEC_ZW-1:0] z_reg;
    logic [VEC_AUX_W-1:0]     aux_reg;

    assign sx = y_i >>> STEP;
    assign sy = x_i >>> STEP;

    always_ff @(posedge aclk) begin
        if (en) begin
            if (y_i > 0) begin
                x_reg <= x_i + sx;
                y_reg <= y_i - sy;
                z_reg <= z_i + ANG;
            end else begin
                x_reg <= x_i - sx;
                y_reg <= y_i + sy;
                z_reg <= z_i - ANG;
            end
            aux_reg <= aux_i;
        end
    end

    assign x_o   = x_reg;
    assign y_o   = y_reg;
    assign z_o   = z_reg;
    assign aux_o = aux_reg;

endmodule

// ===== src/dsk_div_cell.sv =====
// ----------------------------------------------------------------------------
// dsk_div_cell
// One restoring division step: one quotient bit per cell.
// ----------------------------------------------------------------------------
module dsk_div_cell import dsk_pkg::*; #(
    parameter int BIT = 0
) (
    input  logic                  aclk,
    input  logic                  en,
    input  logic [SPAN_W-1:0]     span,
    input  logic [DIV_RW-1:0]     rem_i,
    input  logic [DIV_QW-1:0]     q_i,
    input  logic [SPAN_W-1:0]     num_i,
    input  logic [DIV_AUX_W-1:0]  aux_i,
    output logic [DIV_RW-1:0]     rem_o,
    output logic [DIV_QW-1:0]     q_o,
    output logic [SPAN_W-1:0]     num_o,
    output logic [DIV_AUX_W-1:0]  aux_o
);

    logic                 dbit, ge;
    logic [DIV_RW-1:0]    rem_sh, rem_reg;
    logic [DIV_QW-1:0]    q_reg;
    logic [SPAN_W-1:0]    num_reg;
    logic [DIV_AUX_W-1:0] aux_reg;

    if (BIT >= 16) begin : g_bit
        assign dbit = num_i[BIT-16];
    end else begin : g_zero
        assign dbit = 1'b0;
    end

    assign rem_sh = {rem_i[DIV_RW-2:0], dbit};
    assign ge     = rem_sh >= {1'b0, span};

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg <= ge ? rem_sh - {1'b0, span} : rem_sh;
            q_reg   <= {q_i[DIV_QW-2:0], ge};
            num_reg <= num_i;
            aux_reg <= aux_i;
        end
    end

    assign rem_o = rem_reg;
    assign q_o   = q_reg;
    assign num_o = num_reg;
    assign aux_o = aux_reg;

endmodule

// ===== src/dsk_rot_cell.sv =====
// ----------------------------------------------------------------------------
// dsk_rot_cell
// One rotation-mode CORDIC micro-rotation, registered.
// ----------------------------------------------------------------------------
module dsk_rot_cell import dsk_pkg::*; #(
    parameter int STEP = 0
) (
    input  logic                     aclk,
    input  logic                     en,
    input  logic signed [ROT_XW-1:0] x_i,
    input  logic signed [ROT_XW-1:0] y_i,
    input  logic signed [ROT_ZW-1:0] z_i,
    input  logic [ROT_AUX_W-1:0]     aux_i,
    output logic signed [ROT_XW-1:0] x_o,
    output logic signed [ROT_XW-1:0] y_o,
    output logic signed [ROT_ZW-1:0] z_o,
    output logic [ROT_AUX_W-1:0]     aux_o
);

    localparam logic signed [ROT_ZW-1:0] ANG = ROT_ZW'(ATAN_TAB[STEP]);

    logic signed [ROT_XW-1:0] x_reg, y_reg, sx, sy;
    logic signed [ROT_ZW-1:0] z_reg;
    logic [ROT_AUX_W-1:0]     aux_reg;

    assign sx = y_i >>> STEP;
    assign sy = x_i >>> STEP;

    always_ff @(posedge aclk) begin
        if (en) begin
            if (z_i >= 0) begin
                x_reg <= x_i - sx;
                y_reg <= y_i + sy;
                z_reg <= z_i - ANG;
            end else begin
                x_reg <= x_i + sx;
                y_reg <= y_i - sy;
                z_reg <= z_i + ANG;
            end
            aux_reg <= aux_i;
        end
    end

    assign x_o   = x_reg;
    assign y_o   = y_reg;
    assign z_o   = z_reg;
    assign aux_o = aux_reg;

endmodule

// ===== src/lidar_point_motion_deskew.sv =====
// ----------------------------------------------------------------------------
// lidar_point_motion_deskew
// Removes sweep motion (translation and yaw) from streamed lidar points.
// ----------------------------------------------------------------------------
// Input words (s_*) carry one point; result words (m_*) carry the corrected
// point and its sweep fraction. Invalid points and points within 1 cm of the
// origin produce no result word.
// Configuration: cfg_valid/cfg_index/cfg_data, always ready, one register
// per word; write only while the pipeline is empty.
// Throughput: one word per cycle, set by a fully pipelined datapath of
// 25 vectoring CORDIC cells, 18 divider cells and 25 rotation CORDIC cells.
// Stall: when the output register holds a word that is not taken, the whole
// pipeline freezes and s_ready drops; it resumes the cycle m_ready rises.
// Reset: empties the pipeline and returns registers to start 0, span 2*pi,
// zero shift and zero yaw.
// ----------------------------------------------------------------------------
module lidar_point_motion_deskew import dsk_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_x_in,
    input  logic signed [31:0] s_y_in,
    input  logic signed [31:0] s_z_in,
    input  logic               s_point_valid,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_out_x,
    output logic signed [31:0] m_out_y,
    output logic signed [31:0] m_out_z,
    output logic [17:0]        m_time_fraction,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    localparam int NSTG = 81;

    logic en;
    logic [NSTG-1:0] vld_reg;

    logic signed [18:0] start_reg, yaw_reg;
    logic [SPAN_W-1:0]  span_reg;
    logic signed [31:0] shx_reg, shy_reg, shz_reg;

    assign cfg_ready = 1'b1;
    assign en        = !vld_reg[NSTG-1] || m_ready;
    assign s_ready   = en;
    assign m_valid   = vld_reg[NSTG-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg <= '0;
            span_reg  <= 20'd411775;
            shx_reg   <= '0;
            shy_reg   <= '0;
            shz_reg   <= '0;
            yaw_reg   <= '0;
        end else if (cfg_valid) begin
            case (cfg_idx_t'(cfg_index))
                REG_START: start_reg <= cfg_data[18:0];
                REG_SPAN:  span_reg  <= cfg_data[19:0];
                REG_SHX:   shx_reg   <= cfg_data;
                REG_SHY:   shy_reg   <= cfg_data;
                REG_SHZ:   shz_reg   <= cfg_data;
                REG_YAW:   yaw_reg   <= cfg_data[18:0];
                default: ;
            endcase
        end
    end

    // stage 1: input capture
    logic signed [31:0] x1_reg, y1_reg, z1_reg;
    logic               pv1_reg;

    // stage 2: squares and vectoring prep
    logic signed [63:0] sqx2_reg, sqy2_reg, sqz2_reg;
    logic signed [VEC_XW-1:0] vx2_reg, vy2_reg;
    logic signed [VEC_ZW-1:0] base2_reg;
    logic               zero2_reg;
    logic signed [31:0] x2_reg, y2_reg, z2_reg;
    logic               neg1;
    logic signed [32:0] xa1, ya1;

    assign neg1 = x1_reg < 0;
    assign xa1  = neg1 ? -{x1_reg[31], x1_reg} : {x1_reg[31], x1_reg};
    assign ya1  = neg1 ? -{y1_reg[31], y1_reg} : {y1_reg[31], y1_reg};

    // stage 3: range check
    logic [65:0] rsq2;
    logic signed [VEC_XW-1:0] vx [CORDIC_STEPS+1];
    logic signed [VEC_XW-1:0] vy [CORDIC_STEPS+1];
    logic signed [VEC_ZW-1:0] vz [CORDIC_STEPS+1];
    logic [VEC_AUX_W-1:0]     vaux [CORDIC_STEPS+1];
    logic signed [VEC_XW-1:0] vx3_reg, vy3_reg;
    logic [VEC_AUX_W-1:0]     vaux3_reg;

    assign rsq2 = {2'b00, sqx2_reg} + {2'b00, sqy2_reg} + {2'b00, sqz2_reg};

    always_ff @(posedge aclk) begin
        if (en) begin
            x1_reg  <= s_x_in;
            y1_reg  <= s_y_in;
            z1_reg  <= s_z_in;
            pv1_reg <= s_point_valid;

            sqx2_reg  <= x1_reg * x1_reg;
            sqy2_reg  <= y1_reg * y1_reg;
            sqz2_reg  <= z1_reg * z1_reg;
            vx2_reg   <= {{(VEC_XW-57){xa1[32]}}, xa1, 24'b0};
            vy2_reg   <= {{(VEC_XW-57){ya1[32]}}, ya1, 24'b0};
            base2_reg <= !neg1 ? '0 :
                         (y1_reg >= 0) ? VEC_ZW'(PI_Q24) : -VEC_ZW'(PI_Q24);
            zero2_reg <= (x1_reg == 0) && (y1_reg == 0);
            x2_reg    <= x1_reg;
            y2_reg    <= y1_reg;
            z2_reg    <= z1_reg;

            vx3_reg   <= vx2_reg;
            vy3_reg   <= vy2_reg;
            vaux3_reg <= {zero2_reg, base2_reg, x2_reg, y2_reg, z2_reg};
        end
    end

    assign vx[0]   = vx3_reg;
    assign vy[0]   = vy3_reg;
    assign vz[0]   = '0;
    assign vaux[0] = vaux3_reg;

    genvar k;
    for (k = 0; k < CORDIC_STEPS; k++) begin : g_vec
        dsk_vec_cell #(.STEP(k)) u_cell (
            .aclk  (aclk),
            .en    (en),
            .x_i   (vx[k]),
            .y_i   (vy[k]),
            .z_i   (vz[k]),
            .aux_i (vaux[k]),
            .x_o   (vx[k+1]),
            .y_o   (vy[k+1]),
            .z_o   (vz[k+1]),
            .aux_o (vaux[k+1])
        );
    end

    // azimuth, wrap, numerator
    logic               vzero;
    logic signed [VEC_ZW-1:0] vbase;
    logic signed [95:0] vpt;
    logic signed [28:0] azsum;
    logic signed [20:0] ori29_reg;
    logic [95:0]        pt29_reg;

    assign {vzero, vbase, vpt} = vaux[CORDIC_STEPS];
    assign azsum = 29'(vbase) + 29'(vz[CORDIC_STEPS]) + 29'sd128;

    logic signed [20:0] start_w, oriw;
    logic signed [21:0] num_s;
    logic [SPAN_W-1:0]  num29;

    assign start_w = 21'(start_reg);
    assign oriw    = (ori29_reg < start_w) ? ori29_reg + TWO_PI_Q16 : ori29_reg;
    assign num_s   = 22'(oriw) - 22'(start_w);
    assign num29   = num_s[21] ? '0 : num_s[SPAN_W-1:0];

    logic [DIV_RW-1:0]    drem [DIV_QW+1];
    logic [DIV_QW-1:0]    dq   [DIV_QW+1];
    logic [SPAN_W-1:0]    dnum [DIV_QW+1];
    logic [DIV_AUX_W-1:0] daux [DIV_QW+1];
    logic [DIV_RW-1:0]    rem30_reg;
    logic [SPAN_W-1:0]    num30_reg;
    logic [DIV_AUX_W-1:0] daux30_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            ori29_reg  <= vzero ? '0 : 21'(azsum >>> 8);
            pt29_reg   <= vpt;
            rem30_reg  <= DIV_RW'(num29 >> 2);
            num30_reg  <= num29;
            daux30_reg <= {({2'b00, num29} >= {span_reg, 2'b00}), pt29_reg};
        end
    end

    assign drem[0] = rem30_reg;
    assign dq[0]   = '0;
    assign dnum[0] = num30_reg;
    assign daux[0] = daux30_reg;

    for (k = 0; k < DIV_QW; k++) begin : g_div
        dsk_div_cell #(.BIT(DIV_QW-1-k)) u_cell (
            .aclk  (aclk),
            .en    (en),
            .span  (span_reg),
            .rem_i (drem[k]),
            .q_i   (dq[k]),
            .num_i (dnum[k]),
            .aux_i (daux[k]),
            .rem_o (drem[k+1]),
            .q_o   (dq[k+1]),
            .num_o (dnum[k+1]),
            .aux_o (daux[k+1])
        );
    end

    // fraction, motion terms
    logic               dovf;
    logic [95:0]        dpt;
    logic [DIV_QW-1:0]  frac49_reg, frac50_reg, frac51_reg, frac52_reg;
    logic [95:0]        pt49_reg, pt50_reg;
    logic signed [50:0] px50_reg, py50_reg, pz50_reg;
    logic signed [37:0] pyaw50_reg;
    logic signed [18:0] frac_s;

    assign {dovf, dpt} = daux[DIV_QW];
    assign frac_s = {1'b0, frac49_reg};

    logic signed [31:0] x50, y50, z50;
    logic signed [50:0] px_r, py_r, pz_r;
    logic signed [37:0] pyaw_r;

    assign {x50, y50, z50} = pt50_reg;
    assign px_r   = px50_reg + 51'sd32768;
    assign py_r   = py50_reg + 51'sd32768;
    assign pz_r   = pz50_reg + 51'sd32768;
    assign pyaw_r = pyaw50_reg + 38'sd128;

    logic signed [DW-1:0] dx51_reg, dy51_reg, dz51_reg;
    logic signed [DW-1:0] dx52_reg, dy52_reg, dz52_reg;
    logic signed [29:0]   th51_reg, th52_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            frac49_reg <= (dovf || dq[DIV_QW] > FRAC_MAX) ? FRAC_MAX : dq[DIV_QW];
            pt49_reg   <= dpt;

            px50_reg   <= frac_s * shx_reg;
            py50_reg   <= frac_s * shy_reg;
            pz50_reg   <= frac_s * shz_reg;
            pyaw50_reg <= frac_s * yaw_reg;
            pt50_reg   <= pt49_reg;
            frac50_reg <= frac49_reg;

            dx51_reg   <= DW'(x50) - DW'(px_r >>> 16);
            dy51_reg   <= DW'(y50) - DW'(py_r >>> 16);
            dz51_reg   <= DW'(z50) - DW'(pz_r >>> 16);
            th51_reg   <= 30'(pyaw_r >>> 8);
            frac51_reg <= frac50_reg;

            th52_reg   <= (th51_reg > PI_Q24) ? th51_reg - TWO_PI_Q24 :
                          (th51_reg < -PI_Q24) ? th51_reg + TWO_PI_Q24 : th51_reg;
            dx52_reg   <= dx51_reg;
            dy52_reg   <= dy51_reg;
            dz52_reg   <= dz51_reg;
            frac52_reg <= frac51_reg;
        end
    end

    // quadrant fold and rotation chain
    logic signed [ROT_XW-1:0] rx [CORDIC_STEPS+1];
    logic signed [ROT_XW-1:0] ry [CORDIC_STEPS+1];
    logic signed [ROT_ZW-1:0] rz [CORDIC_STEPS+1];
    logic [ROT_AUX_W-1:0]     raux [CORDIC_STEPS+1];
    logic signed [ROT_ZW-1:0] th53_reg;
    logic [ROT_AUX_W-1:0]     raux53_reg;
    logic                     fold52;

    assign fold52 = (th52_reg > HALF_PI_Q24) || (th52_reg < -HALF_PI_Q24);

    always_ff @(posedge aclk) begin
        if (en) begin
            th53_reg   <= (th52_reg > HALF_PI_Q24) ? ROT_ZW'(th52_reg - PI_Q24) :
                          (th52_reg < -HALF_PI_Q24) ? ROT_ZW'(th52_reg + PI_Q24) :
                          ROT_ZW'(th52_reg);
            raux53_reg <= {fold52, dx52_reg, dy52_reg, dz52_reg, frac52_reg};
        end
    end

    assign rx[0]   = INV_GAIN_Q30;
    assign ry[0]   = '0;
    assign rz[0]   = th53_reg;
    assign raux[0] = raux53_reg;

    for (k = 0; k < CORDIC_STEPS; k++) begin : g_rot
        dsk_rot_cell #(.STEP(k)) u_cell (
            .aclk  (aclk),
            .en    (en),
            .x_i   (rx[k]),
            .y_i   (ry[k]),
            .z_i   (rz[k]),
            .aux_i (raux[k]),
            .x_o   (rx[k+1]),
            .y_o   (ry[k+1]),
            .z_o   (rz[k+1]),
            .aux_o (raux[k+1])
        );
    end

    // output rotation
    logic                     rneg;
    logic signed [DW-1:0]     rdx, rdy, rdz;
    logic [DIV_QW-1:0]        rfrac;
    logic signed [ROT_XW-1:0] xn, yn, xr, yr;

    assign {rneg, rdx, rdy, rdz, rfrac} = raux[CORDIC_STEPS];
    assign xn = rneg ? -rx[CORDIC_STEPS] : rx[CORDIC_STEPS];
    assign yn = rneg ? -ry[CORDIC_STEPS] : ry[CORDIC_STEPS];
    assign xr = xn + ROT_XW'(2);
    assign yr = yn + ROT_XW'(2);

    logic signed [31:0]   c79_reg, s79_reg;
    logic signed [DW-1:0] dx79_reg, dy79_reg, dz79_reg, dz80_reg;
    logic [DIV_QW-1:0]    frac79_reg, frac80_reg;
    logic signed [66:0]   cdx80_reg, sdy80_reg, cdy80_reg, sdx80_reg;
    logic signed [67:0]   osx, osy;
    logic signed [31:0]   ox_reg, oy_reg, oz_reg;
    logic [DIV_QW-1:0]    of_reg;

    assign osx = 68'(cdx80_reg) + 68'(sdy80_reg) + 68'sd134217728;
    assign osy = 68'(cdy80_reg) - 68'(sdx80_reg) + 68'sd134217728;

    always_ff @(posedge aclk) begin
        if (en) begin
            c79_reg    <= 32'(xr >>> 2);
            s79_reg    <= 32'(yr >>> 2);
            dx79_reg   <= rdx;
            dy79_reg   <= rdy;
            dz79_reg   <= rdz;
            frac79_reg <= rfrac;

            cdx80_reg  <= c79_reg * dx79_reg;
            sdy80_reg  <= s79_reg * dy79_reg;
            cdy80_reg  <= c79_reg * dy79_reg;
            sdx80_reg  <= s79_reg * dx79_reg;
            dz80_reg   <= dz79_reg;
            frac80_reg <= frac79_reg;

            ox_reg     <= sat32(osx >>> 28);
            oy_reg     <= sat32(osy >>> 28);
            oz_reg     <= sat32(68'(dz80_reg));
            of_reg     <= frac80_reg;
        end
    end

    assign m_out_x         = ox_reg;
    assign m_out_y         = oy_reg;
    assign m_out_z         = oz_reg;
    assign m_time_fraction = of_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg[0] <= s_valid;
            vld_reg[1] <= vld_reg[0] && pv1_reg;
            vld_reg[2] <= vld_reg[1] && (rsq2 >= MIN_RANGE_SQ);
            vld_reg[NSTG-1:3] <= vld_reg[NSTG-2:2];
        end
    end

endmodule

// ===== dv/lidar_point_motion_deskew_chk.sv =====
// ----------------------------------------------------------------------------
// lidar_point_motion_deskew_chk
// Watches the point, result and register channels of the deskew block,
// predicts each corrected point from the accepted words and compares.
// ----------------------------------------------------------------------------
module lidar_point_motion_deskew_chk import dsk_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic signed [31:0] s_x_in,
    input  logic signed [31:0] s_y_in,
    input  logic signed [31:0] s_z_in,
    input  logic               s_point_valid,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic signed [31:0] m_out_x,
    input  logic signed [31:0] m_out_y,
    input  logic signed [31:0] m_out_z,
    input  logic [17:0]        m_time_fraction,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    output int                 fail_count,
    output int                 pending,
    output int                 points_seen,
    output int                 words_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic [17:0]        frac;
    } fix_t;

    fix_t deskewed_q[$];

    logic signed [18:0] r_start;
    logic [19:0]        r_span;
    logic signed [31:0] r_sx, r_sy, r_sz;
    logic signed [18:0] r_yaw;

    localparam longint ATN [25] = '{
        13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
        65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
        16, 8, 4, 2, 1
    };

    function automatic longint rnd_sh(longint v, int s, longint half);
        return (v + half) >>> s;
    endfunction

    function automatic longint azimuth(longint x, longint y);
        longint cx, cy, cz, base, tx, ty;
        cz = 0;
        base = 0;
        if (x == 0 && y == 0) return 0;
        cx = x * 64'sd16777216;
        cy = y * 64'sd16777216;
        if (cx < 0) begin
            base = (cy >= 0) ? 52707179 : -52707179;
            cx = -cx;
            cy = -cy;
        end
        for (int i = 0; i < 25; i++) begin
            tx = cy >>> i;
            ty = cx >>> i;
            if (cy > 0) begin
                cx += tx; cy -= ty; cz += ATN[i];
            end else begin
                cx -= tx; cy += ty; cz -= ATN[i];
            end
        end
        return rnd_sh(base + cz, 8, 128);
    endfunction

    task automatic yaw_cos_sin(input longint th, output longint c, output longint s);
        longint cx, cy, tx, ty;
        bit flip;
        cx = 652032874;
        cy = 0;
        flip = 0;
        while (th > 52707179) th -= 105414357;
        while (th < -52707179) th += 105414357;
        if (th > 26353589) begin
            th -= 52707179; flip = 1;
        end else if (th < -26353589) begin
            th += 52707179; flip = 1;
        end
        for (int i = 0; i < 25; i++) begin
            tx = cy >>> i;
            ty = cx >>> i;
            if (th >= 0) begin
                cx -= tx; cy += ty; th -= ATN[i];
            end else begin
                cx += tx; cy -= ty; th += ATN[i];
            end
        end
        if (flip) begin
            cx = -cx; cy = -cy;
        end
        c = rnd_sh(cx, 2, 2);
        s = rnd_sh(cy, 2, 2);
    endtask

    function automatic longint clip32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    task automatic predict_point(input longint x, input longint y, input longint z);
        longint ori, num, frac, dx, dy, dz, c, s, st;
        fix_t r;
        longint unsigned rsq;
        rsq = longint'(x * x) + longint'(y * y) + longint'(z * z);
        if (rsq < 64'd429497) return;
        st = r_start;
        ori = azimuth(x, y);
        if (ori < st) ori += 411775;
        num = ori - st;
        if (num < 0) num = 0;
        if (r_span == 0) frac = 131072;
        else begin
            frac = (num * 65536) / longint'(r_span);
            if (frac > 131072) frac = 131072;
        end
        dx = x - rnd_sh(frac * longint'(r_sx), 16, 32768);
        dy = y - rnd_sh(frac * longint'(r_sy), 16, 32768);
        dz = z - rnd_sh(frac * longint'(r_sz), 16, 32768);
        yaw_cos_sin(rnd_sh(frac * longint'(r_yaw), 8, 128), c, s);
        r.x = 32'(clip32(rnd_sh(c * dx + s * dy, 28, 64'sd134217728)));
        r.y = 32'(clip32(rnd_sh(c * dy - s * dx, 28, 64'sd134217728)));
        r.z = 32'(clip32(dz));
        r.frac = 18'(frac);
        deskewed_q.insert(deskewed_q.size(), r);
    endtask

    task automatic report(input string what, input longint got, input longint want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        fix_t e;
        if (!aresetn) begin
            r_start = '0; r_span = 20'd411775;
            r_sx = '0; r_sy = '0; r_sz = '0; r_yaw = '0;
            deskewed_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_idx_t'(cfg_index))
                    REG_START: r_start = cfg_data[18:0];
                    REG_SPAN:  r_span = cfg_data[19:0];
                    REG_SHX:   r_sx = cfg_data;
                    REG_SHY:   r_sy = cfg_data;
                    REG_SHZ:   r_sz = cfg_data;
                    REG_YAW:   r_yaw = cfg_data[18:0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                words_seen++;
                if (deskewed_q.size() == 0) report("unexpected word", 0, 0);
                else begin
                    e = deskewed_q.pop_front();
                    if (m_out_x !== e.x) report("out_x", m_out_x, e.x);
                    if (m_out_y !== e.y) report("out_y", m_out_y, e.y);
                    if (m_out_z !== e.z) report("out_z", m_out_z, e.z);
                    if (m_time_fraction !== e.frac)
                        report("time_fraction", m_time_fraction, e.frac);
                end
            end
            if (s_valid && s_ready) begin
                points_seen++;
                if (s_point_valid) predict_point(s_x_in, s_y_in, s_z_in);
            end
        end
        pending = deskewed_q.size();
    end

    initial begin
        fail_count = 0;
        pending = 0;
        points_seen = 0;
        words_seen = 0;
    end
endmodule

// ===== dv/lidar_point_motion_deskew_tb.sv =====
// ----------------------------------------------------------------------------
// lidar_point_motion_deskew_tb
// Streams lidar points through the deskew block over several register
// settings, with bursty input and a stalling receiver; the checker compares.
// ----------------------------------------------------------------------------
module lidar_point_motion_deskew_tb import dsk_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WD_LIMIT = 4000;

    logic               aclk = 0;
    logic               aresetn = 0;
    logic               s_valid = 0;
    logic               s_ready;
    logic signed [31:0] s_x_in = 0, s_y_in = 0, s_z_in = 0;
    logic               s_point_valid = 0;
    logic               m_valid;
    logic               m_ready = 0;
    logic signed [31:0] m_out_x, m_out_y, m_out_z;
    logic [17:0]        m_time_fraction;
    logic               cfg_valid = 0;
    logic               cfg_ready;
    logic [2:0]         cfg_index = 0;
    logic [31:0]        cfg_data = 0;
    int                 fail_count, pending, points_seen, words_seen;
    int                 idle_cycles = 0;
    int                 stall_mode = 0;

    always begin
        #10 aclk = 1;
        #10 aclk = 0;
    end

    lidar_point_motion_deskew dut (.*);

    lidar_point_motion_deskew_chk chk (.*);

    always @(posedge aclk) begin
        case (stall_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= ($urandom_range(0, 3) != 0);
            2: m_ready <= ($urandom_range(0, 2) == 0);
            default: m_ready <= ($urandom_range(0, 19) != 0);
        endcase
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_LIMIT) begin
            $display("Watchdog expired");
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic send_point(input logic [31:0] x, input logic [31:0] y,
                              input logic [31:0] z, input logic pv);
        s_valid <= 1'b1;
        s_x_in <= x; s_y_in <= y; s_z_in <= z; s_point_valid <= pv;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic rest();
        s_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (90) @(posedge aclk);
    endtask

    function automatic logic [31:0] coord();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 2000)) - 1000);
            2: return 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
            default: return 32'($signed($urandom_range(0, 1 << 24)) - (1 << 23));
        endcase
    endfunction

    task automatic random_points(input int n);
        int burst;
        burst = 0;
        for (int i = 0; i < n; i++) begin
            if (burst == 0) begin
                if ($urandom_range(0, 2) != 0) rest();
                burst = $urandom_range(1, 40);
            end
            send_point(coord(), coord(), coord(), $urandom_range(0, 15) != 0);
            burst--;
        end
    endtask

    logic [31:0] setting [6][6];

    initial begin
        setting[0] = '{32'd0, 32'd411775, 32'd0, 32'd0, 32'd0, 32'd0};
        setting[1] = '{-32'sd205887, 32'd823550, 32'h7FFFFFFF, 32'h80000000,
                       32'h7FFFFFFF, 32'd205887};
        setting[2] = '{32'd205887, 32'd1, 32'h80000000, 32'h7FFFFFFF,
                       32'h80000000, -32'sd205887};
        setting[3] = '{32'd100000, 32'd0, 32'd65536, -32'sd131072, 32'd3000, 32'd51471};
        setting[4] = '{32'h0003FFFF, 32'h000FFFFF, 32'd0, 32'd0, 32'd0, 32'h00040000};
        setting[5] = '{32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0};

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: field extremes, rejection edge, origin in plane, invalid flag
        send_point(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 1);
        send_point(32'h80000000, 32'h80000000, 32'h80000000, 1);
        send_point(32'h80000000, 32'h7FFFFFFF, 32'd0, 1);
        send_point(32'd0, 32'd0, 32'd656, 1);
        send_point(32'd0, 32'd0, 32'd655, 1);
        send_point(32'd0, 32'd0, -32'sd65536, 1);
        send_point(32'd0, 32'd0, 32'd0, 1);
        send_point(32'd65536, 32'd0, 32'd0, 0);
        send_point(-32'sd65536, 32'd0, 32'd0, 1);
        send_point(-32'sd65536, -32'sd1, 32'd0, 1);
        send_point(32'd0, 32'd65536, 32'd0, 1);
        send_point(32'd0, -32'sd65536, 32'd0, 1);
        send_point(32'd463, 32'd463, 32'd0, 1);
        send_point(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1);
        drain();

        for (int p = 0; p < 6; p++) begin
            for (int r = 0; r < 6; r++) write_reg(cfg_idx_t'(r), setting[p][r]);
            cfg_valid <= 1'b0;
            stall_mode = p % 4;
            send_point(32'd65536, 32'd0, 32'd0, 1);
            send_point(-32'sd65536, 32'd0, 32'd0, 1);
            random_points(130);
            drain();
        end
        for (int p = 0; p < 6; p++) begin
            write_reg(REG_START, 32'($signed($urandom_range(0, 411774)) - 205887));
            write_reg(REG_SPAN, $urandom_range(1, 823550));
            write_reg(REG_SHX, $urandom);
            write_reg(REG_SHY, 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21)));
            write_reg(REG_SHZ, $urandom);
            write_reg(REG_YAW, 32'($signed($urandom_range(0, 411774)) - 205887));
            cfg_valid <= 1'b0;
            stall_mode = $urandom_range(0, 3);
            random_points(130);
            drain();
        end

        $display("Covered %0d points and %0d result words over 12 register settings.",
                 points_seen, words_seen);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule

// ===== files.f =====
src/dsk_pkg.sv
src/dsk_vec_cell.sv
src/dsk_div_cell.sv
src/dsk_rot_cell.sv
src/lidar_point_motion_deskew.sv
dv/lidar_point_motion_deskew_chk.sv
dv/lidar_point_motion_deskew_tb.sv
